### design/etr_pkg.sv
// Shared types and constants of the event trace ring.
`timescale 1ns / 1ps
`default_nettype none
package etr_pkg;

   // Command codes
   localparam logic [1:0] CMD_LOG    = 2'd0;
   localparam logic [1:0] CMD_READ   = 2'd1;
   localparam logic [1:0] CMD_DIGEST = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   // Hash: FNV-1a style, prime 0x100000001B3, custom offset basis
   localparam logic [63:0] FNV_BASIS = 64'h517c_c1b7_2722_0a95;

   // Bytes hashed per entry and the bit image that carries them
   localparam int ENTRY_BYTES = 28;
   localparam int ENTRY_BITS  = ENTRY_BYTES * 8;

   typedef struct packed {
      logic [31:0] sequence_no;
      logic [7:0]  kind;
      logic [63:0] entity;
      logic [63:0] value;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic init;   // load offset basis
      logic step;   // mix one byte
   } hash_ctl_type;

endpackage
`default_nettype wire

### design/etr_hash_unit.sv
// Shared one-byte-per-cycle FNV-1a style hash step with its accumulator.
`timescale 1ns / 1ps
`default_nettype none
module etr_hash_unit (
   input  wire logic                  clock,
   input  wire etr_pkg::hash_ctl_type hash_ctl,
   input  wire logic [7:0]            byte_in,
   output logic [63:0]                hash_out
);

   logic [63:0] hash_ff;
   logic [63:0] hash_in;
   logic [63:0] mixed;

   // x * 0x100000001B3 = (x << 40) + x * 0x1B3, 0x1B3 = 256+128+32+16+2+1
   always_comb begin
      mixed   = hash_ff ^ {56'd0, byte_in};
      hash_in = (mixed << 40) + (mixed << 8) + (mixed << 7) + (mixed << 5)
              + (mixed << 4) + (mixed << 1) + mixed;
   end

   always_ff @(posedge clock) begin
      if (hash_ctl.init) begin
         hash_ff <= etr_pkg::FNV_BASIS;
      end else if (hash_ctl.step) begin
         hash_ff <= hash_in;
      end
   end

   assign hash_out = hash_ff;

endmodule
`default_nettype wire

### design/event_trace_ring_with_digest.sv
// Top level of the event trace ring with 64-bit digest.
`timescale 1ns / 1ps
`default_nettype none
// Event trace ring with digest. Each request word carries one command: log stores
// kind, entity, value and stamp with a running sequence number, overwriting the
// oldest entry once RING_DEPTH entries are held; read returns the entry at a given
// age (0 = oldest); digest hashes all readable entries oldest to newest, 28
// little-endian bytes each, and flags a mismatch against the expected digest;
// clear empties the ring. Every request gives exactly one response word carrying
// the counters as they stand after the command. Log and clear finish in the
// execute state, read adds one registered read of the entry memory, and digest
// does one memory read plus 28 passes through the shared byte-wide hash step per
// readable entry. The block takes one request at a time and is ready again once
// the previous result sits in the response register, so a new request is accepted
// while that word waits; a stalled response channel only delays the end of the
// following command. Entry memory has no reset: the counters keep unwritten
// entries out of every response.
module event_trace_ring_with_digest #(
   parameter int RING_DEPTH = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_command,
   input  wire logic [7:0]  req_event_kind,
   input  wire logic [63:0] req_entity_ref,
   input  wire logic [63:0] req_sample_value,
   input  wire logic [31:0] req_trace_stamp,
   input  wire logic [7:0]  req_read_index,
   input  wire logic [63:0] req_golden_digest,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_total_logged,
   output logic [8:0]       rsp_readable_count,
   output logic             rsp_overflowed,
   output logic             rsp_read_found,
   output logic [31:0]      rsp_entry_sequence,
   output logic [7:0]       rsp_entry_kind,
   output logic [63:0]      rsp_entry_entity,
   output logic [63:0]      rsp_entry_value,
   output logic [31:0]      rsp_entry_stamp,
   output logic [63:0]      rsp_digest,
   output logic             rsp_diverged
);

   localparam int AW = $clog2(RING_DEPTH);       // slot address bits
   localparam int CW = $clog2(RING_DEPTH + 1);   // entry count bits

   localparam logic [CW-1:0] DEPTH_CNT  = CW'(RING_DEPTH);
   localparam logic [AW:0]   DEPTH_SUM  = (AW+1)'(RING_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT  = AW'(RING_DEPTH - 1);
   localparam logic [31:0]   DEPTH_TOT  = 32'(RING_DEPTH);
   localparam logic [4:0]    BYTE_LAST  = 5'(etr_pkg::ENTRY_BYTES - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_RDATA = 3'd2;
   localparam logic [2:0] S_DLOAD = 3'd3;
   localparam logic [2:0] S_DBYTE = 3'd4;
   localparam logic [2:0] S_DFIN  = 3'd5;

   // slot of an age: oldest sits at write_slot once the ring has wrapped
   function automatic logic [AW-1:0] slot_of(input logic wrap, input logic [AW-1:0] ws,
                                             input logic [AW-1:0] age);
      logic [AW:0] sum;
      sum = {1'b0, ws} + {1'b0, age};
      if (sum >= DEPTH_SUM) begin
         sum = sum - DEPTH_SUM;
      end
      return wrap ? sum[AW-1:0] : age;
   endfunction

   // when not wrapped the total never exceeds the depth
   function automatic logic [CW-1:0] readable_of(input logic wrap, input logic [31:0] tot);
      logic [CW+31:0] tot_ext;
      tot_ext = {{CW{1'b0}}, tot};
      return wrap ? DEPTH_CNT : tot_ext[CW-1:0];
   endfunction

   // little-endian byte image: sequence, kind as 32 bits, entity, value, stamp
   function automatic logic [etr_pkg::ENTRY_BITS-1:0] bytes_of(input etr_pkg::entry_type e);
      return {e.stamp, e.value, e.entity, 24'd0, e.kind, e.sequence_no};
   endfunction

   // ---------------- registers ----------------
   logic [2:0]  state_ff, state_in;
   logic [1:0]  cmd_ff;
   logic [7:0]  kind_ff, index_ff;
   logic [63:0] entity_ff, value_ff, expect_ff;
   logic [31:0] stamp_ff;

   logic [AW-1:0] write_slot_ff, write_slot_in;
   logic [31:0]   event_total_ff, event_total_in;
   logic [31:0]   next_seq_ff, next_seq_in;
   logic          wrapped_ff, wrapped_in;

   logic          found_ff, found_in;
   logic [CW-1:0] age_ff, age_in;
   logic [CW-1:0] count_ff, count_in;
   logic [4:0]    byte_cnt_ff, byte_cnt_in;
   logic [etr_pkg::ENTRY_BITS-1:0] bytes_ff, bytes_in;

   etr_pkg::entry_type ring_mem [RING_DEPTH];
   etr_pkg::entry_type rdata_ff;

   logic rsp_valid_ff;

   // ---------------- control ----------------
   logic                  req_take, out_free, rsp_load;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         mem_raddr;
   etr_pkg::entry_type    mem_wdata;
   etr_pkg::hash_ctl_type hash_ctl;
   logic [63:0]           hash_val;

   logic [CW-1:0]   readable_now, readable_in;
   logic [AW+7:0]   index_ext;
   logic [CW+7:0]   index_cmp, readable_cmp;
   logic [CW-1:0]   next_age;
   logic [CW+8:0]   readable_out_ext;

   assign req_ready = (state_ff == S_IDLE);
   assign req_take  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign readable_now = readable_of(wrapped_ff, event_total_ff);
   assign readable_in  = readable_of(wrapped_in, event_total_in);
   assign index_ext    = {{AW{1'b0}}, index_ff};
   assign index_cmp    = {{CW{1'b0}}, index_ff};
   assign readable_cmp = {8'd0, readable_now};
   assign next_age     = age_ff + CW'(1);
   assign readable_out_ext = {9'd0, readable_in};

   always_comb begin
      mem_wdata.sequence_no = next_seq_ff;
      mem_wdata.kind        = kind_ff;
      mem_wdata.entity      = entity_ff;
      mem_wdata.value       = value_ff;
      mem_wdata.stamp       = stamp_ff;
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      write_slot_in  = write_slot_ff;
      event_total_in = event_total_ff;
      next_seq_in    = next_seq_ff;
      wrapped_in     = wrapped_ff;
      found_in       = found_ff;
      age_in         = age_ff;
      count_in       = count_ff;
      byte_cnt_in    = byte_cnt_ff;
      bytes_in       = bytes_ff;
      mem_we         = 1'b0;
      mem_re         = 1'b0;
      mem_raddr      = slot_of(wrapped_ff, write_slot_ff, index_ext[AW-1:0]);
      hash_ctl       = '0;
      rsp_load       = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff)
               etr_pkg::CMD_LOG: begin
                  if (out_free) begin
                     mem_we         = 1'b1;
                     wrapped_in     = wrapped_ff || (event_total_ff >= DEPTH_TOT);
                     next_seq_in    = next_seq_ff + 32'd1;
                     write_slot_in  = (write_slot_ff == LAST_SLOT) ? '0
                                    : write_slot_ff + AW'(1);
                     event_total_in = event_total_ff + 32'd1;
                     rsp_load       = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               etr_pkg::CMD_READ: begin
                  mem_re   = 1'b1;
                  found_in = (index_cmp < readable_cmp);
                  state_in = S_RDATA;
               end
               etr_pkg::CMD_DIGEST: begin
                  hash_ctl.init = 1'b1;
                  age_in        = '0;
                  count_in      = readable_now;
                  mem_raddr     = slot_of(wrapped_ff, write_slot_ff, '0);
                  mem_re        = 1'b1;
                  state_in      = (readable_now == '0) ? S_DFIN : S_DLOAD;
               end
               etr_pkg::CMD_CLEAR: begin
                  if (out_free) begin
                     write_slot_in  = '0;
                     event_total_in = '0;
                     next_seq_in    = '0;
                     wrapped_in     = 1'b0;
                     rsp_load       = 1'b1;
                     state_in       = S_IDLE;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_RDATA: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DLOAD: begin
            bytes_in    = bytes_of(rdata_ff);
            byte_cnt_in = '0;
            state_in    = S_DBYTE;
         end
         S_DBYTE: begin
            hash_ctl.step = 1'b1;
            bytes_in      = bytes_ff >> 8;
            byte_cnt_in   = byte_cnt_ff + 5'd1;
            if (byte_cnt_ff == BYTE_LAST) begin
               age_in = next_age;
               if (next_age == count_ff) begin
                  state_in = S_DFIN;
               end else begin
                  mem_raddr = slot_of(wrapped_ff, write_slot_ff, next_age[AW-1:0]);
                  mem_re    = 1'b1;
                  state_in  = S_DLOAD;
               end
            end
         end
         S_DFIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         write_slot_ff  <= '0;
         event_total_ff <= '0;
         next_seq_ff    <= '0;
         wrapped_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         write_slot_ff  <= write_slot_in;
         event_total_ff <= event_total_in;
         next_seq_ff    <= next_seq_in;
         wrapped_ff     <= wrapped_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // captured request and walk registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         cmd_ff    <= req_command;
         kind_ff   <= req_event_kind;
         entity_ff <= req_entity_ref;
         value_ff  <= req_sample_value;
         stamp_ff  <= req_trace_stamp;
         index_ff  <= req_read_index;
         expect_ff <= req_golden_digest;
      end
      found_ff    <= found_in;
      age_ff      <= age_in;
      count_ff    <= count_in;
      byte_cnt_ff <= byte_cnt_in;
      bytes_ff    <= bytes_in;
   end

   // entry memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[write_slot_ff] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[mem_raddr];
      end
   end

   etr_hash_unit u_hash (
      .clock    (clock),
      .hash_ctl (hash_ctl),
      .byte_in  (bytes_ff[7:0]),
      .hash_out (hash_val)
   );

   // response word; entry and digest fields read zero outside their commands
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_total_logged   <= event_total_in;
         rsp_readable_count <= readable_out_ext[8:0];
         rsp_overflowed     <= wrapped_in;
         if (state_ff == S_RDATA && found_ff) begin
            rsp_read_found     <= 1'b1;
            rsp_entry_sequence <= rdata_ff.sequence_no;
            rsp_entry_kind     <= rdata_ff.kind;
            rsp_entry_entity   <= rdata_ff.entity;
            rsp_entry_value    <= rdata_ff.value;
            rsp_entry_stamp    <= rdata_ff.stamp;
         end else begin
            rsp_read_found     <= 1'b0;
            rsp_entry_sequence <= '0;
            rsp_entry_kind     <= '0;
            rsp_entry_entity   <= '0;
            rsp_entry_value    <= '0;
            rsp_entry_stamp    <= '0;
         end
         if (state_ff == S_DFIN) begin
            rsp_digest   <= hash_val;
            rsp_diverged <= (hash_val != expect_ff);
         end else begin
            rsp_digest   <= '0;
            rsp_diverged <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

### tb/event_trace_ring_with_digest_tb.sv
// Self-checking testbench for the event trace ring with digest.
`timescale 1ns / 1ps
module event_trace_ring_with_digest_tb;

   localparam int          RING_DEPTH   = 256;
   localparam logic [63:0] HASH_PRIME   = 64'h0000_0100_0000_01B3;
   localparam int          RANDOM_ITEMS = 1030;
   localparam int          FIRST_RUN    = 520;   // long enough to wrap the ring
   localparam int          DRAIN_CYCLES = 40;
   // a few dozen full-ring digests plus stalls stay well under this limit
   localparam int          CYCLE_LIMIT  = 3_000_000;

   // one request word
   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  event_kind;
      logic [63:0] entity_ref;
      logic [63:0] sample_value;
      logic [31:0] trace_stamp;
      logic [7:0]  read_index;
      logic [63:0] golden_digest;
   } trace_req_type;

   // one response word
   typedef struct packed {
      logic [31:0] total_logged;
      logic [8:0]  readable_count;
      logic        overflowed;
      logic        read_found;
      logic [31:0] entry_sequence;
      logic [7:0]  entry_kind;
      logic [63:0] entry_entity;
      logic [63:0] entry_value;
      logic [31:0] entry_stamp;
      logic [63:0] digest;
      logic        diverged;
   } trace_rsp_type;

   // directed row: hash_match swaps in the predicted digest as the expected
   // one; typed rows carry their response, the others go to the predictor
   typedef struct packed {
      trace_req_type req;
      logic          hash_match;
      logic          typed;
      trace_rsp_type rsp;
   } directed_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_command;
   logic [7:0]  req_event_kind;
   logic [63:0] req_entity_ref;
   logic [63:0] req_sample_value;
   logic [31:0] req_trace_stamp;
   logic [7:0]  req_read_index;
   logic [63:0] req_golden_digest;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_total_logged;
   logic [8:0]  rsp_readable_count;
   logic        rsp_overflowed;
   logic        rsp_read_found;
   logic [31:0] rsp_entry_sequence;
   logic [7:0]  rsp_entry_kind;
   logic [63:0] rsp_entry_entity;
   logic [63:0] rsp_entry_value;
   logic [31:0] rsp_entry_stamp;
   logic [63:0] rsp_digest;
   logic        rsp_diverged;

   event_trace_ring_with_digest #(.RING_DEPTH(RING_DEPTH)) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_command         (req_command),
      .req_event_kind      (req_event_kind),
      .req_entity_ref      (req_entity_ref),
      .req_sample_value    (req_sample_value),
      .req_trace_stamp     (req_trace_stamp),
      .req_read_index      (req_read_index),
      .req_golden_digest   (req_golden_digest),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_total_logged    (rsp_total_logged),
      .rsp_readable_count  (rsp_readable_count),
      .rsp_overflowed      (rsp_overflowed),
      .rsp_read_found      (rsp_read_found),
      .rsp_entry_sequence  (rsp_entry_sequence),
      .rsp_entry_kind      (rsp_entry_kind),
      .rsp_entry_entity    (rsp_entry_entity),
      .rsp_entry_value     (rsp_entry_value),
      .rsp_entry_stamp     (rsp_entry_stamp),
      .rsp_digest          (rsp_digest),
      .rsp_diverged        (rsp_diverged)
   );

   // ---------------------------------------------------------------------
   // Shadow of the trace ring
   // ---------------------------------------------------------------------
   etr_pkg::entry_type trace_mem [RING_DEPTH];
   int          head_slot;       // next slot a log lands in
   logic [31:0] logged_total;    // wraps at 2^32
   logic [31:0] seq_next;
   logic        wrap_seen;       // sticky until clear

   trace_rsp_type    pending_trace_rsp [$];
   directed_row_type directed_rows [$];
   int               mismatch_count;
   int               cycle_count;
   logic             calm;       // no idling on either side while set

   function automatic int readable_entries();
      if (wrap_seen || logged_total > RING_DEPTH)
         return RING_DEPTH;
      return int'(logged_total);
   endfunction

   // age 0 is the oldest; once wrapped the oldest sits at the write slot
   function automatic int age_slot(input int age);
      if (wrap_seen)
         return (head_slot + age) % RING_DEPTH;
      return age % RING_DEPTH;
   endfunction

   function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] v,
                                           input int nbytes);
      for (int i = 0; i < nbytes; i++) begin
         h = h ^ {56'd0, v[8*i +: 8]};
         h = h * HASH_PRIME;
      end
      return h;
   endfunction

   // 28 little-endian bytes per entry: seq, kind as 32 bits, entity, value, stamp
   function automatic logic [63:0] ring_digest();
      logic [63:0]        h;
      etr_pkg::entry_type e;
      h = etr_pkg::FNV_BASIS;
      for (int age = 0; age < readable_entries(); age++) begin
         e = trace_mem[age_slot(age)];
         h = fnv_mix(h, {32'd0, e.sequence_no}, 4);
         h = fnv_mix(h, {56'd0, e.kind}, 4);
         h = fnv_mix(h, e.entity, 8);
         h = fnv_mix(h, e.value, 8);
         h = fnv_mix(h, {32'd0, e.stamp}, 4);
      end
      return h;
   endfunction

   // applies one accepted word to the shadow ring and returns its response
   function automatic trace_rsp_type trace_ring_step(input trace_req_type w);
      trace_rsp_type      r;
      etr_pkg::entry_type e;
      int                 idx;
      r = '0;
      case (w.command)
         etr_pkg::CMD_LOG: begin
            if (logged_total >= RING_DEPTH)
               wrap_seen = 1'b1;
            e.sequence_no = seq_next;
            e.kind        = w.event_kind;
            e.entity      = w.entity_ref;
            e.value       = w.sample_value;
            e.stamp       = w.trace_stamp;
            trace_mem[head_slot] = e;
            seq_next     = seq_next + 32'd1;
            head_slot    = (head_slot + 1) % RING_DEPTH;
            logged_total = logged_total + 32'd1;
         end
         etr_pkg::CMD_READ: begin
            idx = int'(w.read_index);
            if (idx < readable_entries()) begin
               e = trace_mem[age_slot(idx)];
               r.read_found     = 1'b1;
               r.entry_sequence = e.sequence_no;
               r.entry_kind     = e.kind;
               r.entry_entity   = e.entity;
               r.entry_value    = e.value;
               r.entry_stamp    = e.stamp;
            end
         end
         etr_pkg::CMD_DIGEST: begin
            r.digest   = ring_digest();
            r.diverged = (r.digest != w.golden_digest);
         end
         etr_pkg::CMD_CLEAR: begin
            head_slot    = 0;
            logged_total = '0;
            seq_next     = '0;
            wrap_seen    = 1'b0;
         end
      endcase
      r.total_logged   = logged_total;
      r.readable_count = 9'(readable_entries());
      r.overflowed     = wrap_seen;
      return r;
   endfunction

   function automatic trace_req_type req_of(input logic [1:0] cmd, input logic [7:0] kind,
                                            input logic [63:0] ent, input logic [63:0] val,
                                            input logic [31:0] stamp, input logic [7:0] idx,
                                            input logic [63:0] dig);
      trace_req_type w;
      w = '{cmd, kind, ent, val, stamp, idx, dig};
      return w;
   endfunction

   function automatic trace_rsp_type rsp_of(input logic [31:0] total, input logic [8:0] rd,
                                            input logic ovf, input logic found,
                                            input logic [31:0] seq, input logic [7:0] kind,
                                            input logic [63:0] ent, input logic [63:0] val,
                                            input logic [31:0] stamp, input logic [63:0] dig,
                                            input logic div);
      trace_rsp_type r;
      r = '{total, rd, ovf, found, seq, kind, ent, val, stamp, dig, div};
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endfunction

   // Drives one word from the falling edge and holds it until accepted. The
   // expectation is queued at the accepting edge, so it always precedes its
   // response.
   task automatic send_trace_req(input trace_req_type w, input logic typed,
                                 input trace_rsp_type typed_rsp);
      trace_rsp_type predicted;
      @(negedge clock);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= w.command;
      req_event_kind    <= w.event_kind;
      req_entity_ref    <= w.entity_ref;
      req_sample_value  <= w.sample_value;
      req_trace_stamp   <= w.trace_stamp;
      req_read_index    <= w.read_index;
      req_golden_digest <= w.golden_digest;
      do @(posedge clock); while (req_ready !== 1'b1);
      predicted = trace_ring_step(w);
      pending_trace_rsp.push_back(typed ? typed_rsp : predicted);
   endtask

   // ---------------------------------------------------------------------
   // Clock, response-side stall, watchdog
   // ---------------------------------------------------------------------
   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= calm || ($urandom_range(0, 99) >= 31);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Response checker: every accepted word against the oldest expectation
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      trace_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_trace_rsp.size() == 0) begin
            mismatch_count++;
            $display("%0t: response word with no request waiting", $time);
         end else begin
            want = pending_trace_rsp.pop_front();
            check_field("total_logged",   want.total_logged,   rsp_total_logged);
            check_field("readable_count", want.readable_count, rsp_readable_count);
            check_field("overflowed",     want.overflowed,     rsp_overflowed);
            check_field("read_found",     want.read_found,     rsp_read_found);
            check_field("entry_sequence", want.entry_sequence, rsp_entry_sequence);
            check_field("entry_kind",     want.entry_kind,     rsp_entry_kind);
            check_field("entry_entity",   want.entry_entity,   rsp_entry_entity);
            check_field("entry_value",    want.entry_value,    rsp_entry_value);
            check_field("entry_stamp",    want.entry_stamp,    rsp_entry_stamp);
            check_field("digest",         want.digest,         rsp_digest);
            check_field("diverged",       want.diverged,       rsp_diverged);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      directed_row_type row;
      trace_req_type    w;
      trace_rsp_type    nil;
      int               sent;
      int               run_len;
      int               pick;
      int               rd;
      bit               first_run;

      nil            = '0;
      mismatch_count = 0;
      cycle_count    = 0;
      calm           = 1'b0;
      head_slot      = 0;
      logged_total   = '0;
      seq_next       = '0;
      wrap_seen      = 1'b0;

      reset             = 1'b1;
      req_valid         = 1'b0;
      req_command       = etr_pkg::CMD_LOG;
      req_event_kind    = '0;
      req_entity_ref    = '0;
      req_sample_value  = '0;
      req_trace_stamp   = '0;
      req_read_index    = '0;
      req_golden_digest = '0;
      rsp_ready         = 1'b0;

      // --- directed table ---
      // empty ring: nothing readable, digest is the bare offset basis
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b0, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0,
                                       etr_pkg::FNV_BASIS),
                                1'b0, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, etr_pkg::FNV_BASIS, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0, 64'd0),
                                1'b0, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, etr_pkg::FNV_BASIS, 1)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_CLEAR, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b0, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      // all-ones and all-zeros entries
      directed_rows.push_back('{req_of(etr_pkg::CMD_LOG, 8'hFF, '1, '1, '1, 8'd0, '0),
                                1'b0, 1'b1, rsp_of(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_LOG, 8'h00, '0, '0, '0, 8'hFF, '1),
                                1'b0, 1'b1, rsp_of(2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b0, 1'b1, rsp_of(2, 2, 0, 1, 0, 8'hFF, '1, '1, '1, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd1, '0),
                                1'b0, 1'b1, rsp_of(2, 2, 0, 1, 1, 0, 0, 0, 0, 0, 0)});
      // read out of range: at the count and at the top index
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd2, '0),
                                1'b0, 1'b1, rsp_of(2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'hFF, '0),
                                1'b0, 1'b1, rsp_of(2, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0, '1),
                                1'b0, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_LOG, 8'h80, 64'h8000_0000_0000_0001,
                                       64'h0123_4567_89AB_CDEF, 32'h8000_0001, 8'd0, '0),
                                1'b0, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_LOG, 8'h5A, 64'hA5A5_A5A5_A5A5_A5A5,
                                       64'h5A5A_5A5A_5A5A_5A5A, 32'h7FFF_FFFF, 8'd0, '0),
                                1'b0, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd2, '0),
                                1'b0, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd3, '0),
                                1'b0, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b1, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b0, 1'b0, nil});
      // clear drops everything; sequence restarts at zero
      directed_rows.push_back('{req_of(etr_pkg::CMD_CLEAR, 8'hFF, '1, '1, '1, 8'hFF, '1),
                                1'b0, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b0, 1'b1, rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0,
                                       etr_pkg::FNV_BASIS),
                                1'b0, 1'b1,
                                rsp_of(0, 0, 0, 0, 0, 0, 0, 0, 0, etr_pkg::FNV_BASIS, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_LOG, 8'h01, 64'd7, 64'd9, 32'd11, 8'd0, '0),
                                1'b0, 1'b1, rsp_of(1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0)});
      directed_rows.push_back('{req_of(etr_pkg::CMD_READ, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b0, 1'b0, nil});
      directed_rows.push_back('{req_of(etr_pkg::CMD_DIGEST, 8'h00, '0, '0, '0, 8'd0, '0),
                                1'b1, 1'b0, nil});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         w   = row.req;
         if (row.hash_match)
            w.golden_digest = ring_digest();
         send_trace_req(w, row.typed, row.rsp);
      end

      // --- random runs, each closed by a clear ---
      // The first run is long so the ring wraps and the sticky overflow flag
      // gets exercised; later runs are short and keep digests cheap.
      sent      = 0;
      first_run = 1'b1;
      while (sent < RANDOM_ITEMS) begin
         run_len   = first_run ? FIRST_RUN : $urandom_range(5, 200);
         first_run = 1'b0;
         for (int k = 0; k < run_len && sent < RANDOM_ITEMS; k++) begin
            calm = (sent >= 300 && sent < 450);
            pick = $urandom_range(0, 99);
            if (pick < 62)
               w.command = etr_pkg::CMD_LOG;
            else if (pick < 95)
               w.command = etr_pkg::CMD_READ;
            else
               w.command = etr_pkg::CMD_DIGEST;
            w.event_kind = 8'($urandom);
            case ($urandom_range(0, 15))
               0:       w.entity_ref = '1;
               1:       w.entity_ref = '0;
               default: w.entity_ref = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 15))
               0:       w.sample_value = '1;
               1:       w.sample_value = '0;
               default: w.sample_value = {$urandom, $urandom};
            endcase
            w.trace_stamp = $urandom;
            // read index: anywhere, or hugging the readable count
            rd = readable_entries();
            case ($urandom_range(0, 3))
               0: w.read_index = 8'($urandom);
               1: w.read_index = (rd > 0) ? 8'(rd - 1) : 8'd0;
               2: w.read_index = (rd > 255) ? 8'hFF : 8'(rd);
               default: w.read_index = (rd > 0) ? 8'($urandom_range(0, rd - 1)) : 8'd0;
            endcase
            // expected digest: half the time right, else off by one bit or junk
            case ($urandom_range(0, 3))
               0, 1: w.golden_digest = ring_digest();
               2:    w.golden_digest = ring_digest() ^ (64'd1 << $urandom_range(0, 63));
               default: w.golden_digest = {$urandom, $urandom};
            endcase
            send_trace_req(w, 1'b0, nil);
            sent++;
         end
         w = req_of(etr_pkg::CMD_CLEAR, 8'($urandom), {$urandom, $urandom},
                    {$urandom, $urandom}, $urandom, 8'($urandom), {$urandom, $urandom});
         send_trace_req(w, 1'b0, nil);
         sent++;
      end
      calm = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;

      // wait out every response, then drain for anything stray
      while (pending_trace_rsp.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### filelist.f
design/etr_pkg.sv
design/etr_hash_unit.sv
design/event_trace_ring_with_digest.sv
tb/event_trace_ring_with_digest_tb.sv
